// File: hdl/sorted_table_binary_search_core_macros.svh
// ----------------------------------------------------------------------------
// sorted table binary search - assertion macros
// clocked assertions with an active-low disable, reported through $error
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_MACROS_SVH

// same-cycle implication
`define STBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define STBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// shared constants and types of the sorted table binary search core
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int unsigned MAX_ROWS_DEF    = 32;
  localparam int unsigned MAX_COLUMNS_DEF = 32;

  localparam int unsigned CNT_W   = 6;
  localparam int unsigned PROD_W  = 2 * CNT_W;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  // item actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef logic signed [VALUE_W-1:0] value_t;

  // requests from the top level to the search sequencer
  typedef struct packed {
    logic   start;
    logic   ack;
    value_t target;
  } seq_req_t;

  // status from the search sequencer
  typedef struct packed {
    logic idle;
    logic done;
    logic found;
  } seq_rsp_t;

endpackage

// File: hdl/stbs_if.sv
// ----------------------------------------------------------------------------
// stbs_if
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface stbs_in_if;
  logic                 valid;
  logic                 ready;
  logic                 action;
  stbs_pkg::value_t     value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface stbs_out_if;
  logic valid;
  logic ready;
  logic found;

  modport source (output valid, output found, input ready);
  modport sink   (input valid, input found, output ready);
endinterface

// File: hdl/stbs_store.sv
// ----------------------------------------------------------------------------
// stbs_store
// element memory: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module stbs_store #(
  parameter int unsigned DEPTH = stbs_pkg::MAX_ROWS_DEF * stbs_pkg::MAX_COLUMNS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  stbs_pkg::value_t                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output stbs_pkg::value_t                        rdata_o
);

  stbs_pkg::value_t mem_q [DEPTH];
  stbs_pkg::value_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/stbs_seq.sv
// ----------------------------------------------------------------------------
// stbs_seq
// binary search sequencer: one probe per cycle over the shared compare unit
// ----------------------------------------------------------------------------
module stbs_seq #(
  parameter int unsigned DEPTH = stbs_pkg::MAX_ROWS_DEF * stbs_pkg::MAX_COLUMNS_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned SW   = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stbs_pkg::seq_req_t req_i,
  input  logic [SW-1:0]      total_i,
  output stbs_pkg::seq_rsp_t rsp_o,
  output logic               re_o,
  output logic [AW-1:0]      raddr_o,
  input  stbs_pkg::value_t   rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROBE = 3'b010,
    S_DONE  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [SW-1:0]    lo_q, lo_d;
  logic [SW-1:0]    hi_q, hi_d;     // one past the upper bound
  logic [SW-1:0]    mid_q, mid_d;
  stbs_pkg::value_t target_q, target_d;
  logic             found_q, found_d;

  logic             hit, below;
  logic [SW-1:0]    lo_n, hi_n;
  logic [SW:0]      span_sum;
  logic [SW-1:0]    mid_n;
  logic [SW-1:0]    mid_first;

  // shared compare unit and next-probe arithmetic
  assign hit       = (target_q == rdata_i);
  assign below     = (target_q < rdata_i);
  assign lo_n      = below ? lo_q : (mid_q + SW'(1));
  assign hi_n      = below ? mid_q : hi_q;
  assign span_sum  = {1'b0, lo_n} + {1'b0, hi_n} - (SW + 1)'(1);
  assign mid_n     = span_sum[SW:1];
  assign mid_first = (total_i - SW'(1)) >> 1;

  always_comb begin
    state_d  = state_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    target_d = target_q;
    found_d  = found_q;
    re_o     = 1'b0;
    raddr_o  = AW'(mid_first);
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          target_d = req_i.target;
          lo_d     = '0;
          hi_d     = total_i;
          mid_d    = mid_first;
          re_o     = 1'b1;
          state_d  = S_PROBE;
        end
      end
      S_PROBE: begin
        raddr_o = AW'(mid_n);
        if (hit) begin
          found_d = 1'b1;
          state_d = S_DONE;
        end else if (lo_n >= hi_n) begin
          found_d = 1'b0;
          state_d = S_DONE;
        end else begin
          lo_d  = lo_n;
          hi_d  = hi_n;
          mid_d = mid_n;
          re_o  = 1'b1;
        end
      end
      S_DONE: begin
        if (req_i.ack) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    target_q <= target_d;
    found_q  <= found_d;
  end

  assign rsp_o.idle  = (state_q == S_IDLE);
  assign rsp_o.done  = (state_q == S_DONE);
  assign rsp_o.found = found_q;

endmodule

// File: hdl/sorted_table_binary_search_core.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// flat store of ascending signed words, loaded in order, searched by bisection
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  in_if     in   valid / ready   action, value
//  out_if    out  valid / ready   found
//  cfg       in   cfg_we_i        cfg_idx_i, cfg_data_i
//
//  a load item is written when taken and gives no result
//  a query item holds the input off through the first read, the probes and
//  the hand-off; probes <= floor(log2(rows*cols)) + 1, so 11 for 32 x 32
//  reset clears control only; the store is undefined until loaded
//  a finished result waits in the output register; a load may be taken
//  meanwhile, a new query is taken but its result waits for the register
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core #(
  parameter int unsigned MAX_ROWS    = stbs_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLUMNS = stbs_pkg::MAX_COLUMNS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  stbs_in_if.sink                          in_if,
  stbs_out_if.source                       out_if,
  input  logic                             cfg_we_i,
  input  logic [stbs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [stbs_pkg::CNT_W-1:0]       cfg_data_i
);

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW    = $clog2(DEPTH + 1);
  localparam int unsigned CW    = stbs_pkg::CNT_W;

  // configuration registers
  logic [CW-1:0] rows_q, cols_q;
  logic [CW-1:0] rows_eff, cols_eff;
  logic [stbs_pkg::PROD_W-1:0] prod;
  logic [SW-1:0] total;

  // load position and write side
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] wr_pos;
  logic [SW-1:0] wr_next;

  // handshake
  logic in_acc, load_acc, query_acc;

  // sequencer link
  stbs_pkg::seq_req_t seq_req;
  stbs_pkg::seq_rsp_t seq_rsp;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  stbs_pkg::value_t   rd_data;

  // output register
  logic out_valid_q, out_valid_d;
  logic out_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CW'(1);
      cols_q <= CW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        stbs_pkg::REG_ROW_COUNT:    rows_q <= cfg_data_i;
        stbs_pkg::REG_COLUMN_COUNT: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero reads as one, counts saturate at the table limits
  always_comb begin
    rows_eff = rows_q;
    if (rows_q == '0) begin
      rows_eff = CW'(1);
    end else if (32'(rows_q) > MAX_ROWS) begin
      rows_eff = CW'(MAX_ROWS);
    end
    cols_eff = cols_q;
    if (cols_q == '0) begin
      cols_eff = CW'(1);
    end else if (32'(cols_q) > MAX_COLUMNS) begin
      cols_eff = CW'(MAX_COLUMNS);
    end
  end

  // small product; never exceeds the store depth
  assign prod  = stbs_pkg::PROD_W'(rows_eff) * stbs_pkg::PROD_W'(cols_eff);
  assign total = SW'(prod);

  assign in_if.ready = seq_rsp.idle;
  assign in_acc      = in_if.valid && in_if.ready;
  assign load_acc    = in_acc && (in_if.action == stbs_pkg::ACT_LOAD);
  assign query_acc   = in_acc && (in_if.action == stbs_pkg::ACT_QUERY);

  // a position left beyond a shrunken table restarts at zero
  assign wr_pos  = (SW'(pos_q) >= total) ? '0 : pos_q;
  assign wr_next = SW'(wr_pos) + SW'(1);
  assign pos_d   = (wr_next >= total) ? '0 : AW'(wr_next);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (load_acc) begin
      pos_q <= pos_d;
    end
  end

  // result moves on when the output register is free or being drained
  assign seq_req.start  = query_acc;
  assign seq_req.ack    = seq_rsp.done && (!out_valid_q || out_if.ready);
  assign seq_req.target = in_if.value;

  stbs_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_acc),
    .waddr_i (wr_pos),
    .wdata_i (in_if.value),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  stbs_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (seq_req),
    .total_i (total),
    .rsp_o   (seq_rsp),
    .re_o    (rd_en),
    .raddr_o (rd_addr),
    .rdata_i (rd_data)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (seq_req.ack) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_req.ack) begin
      out_found_q <= seq_rsp.found;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.found = out_found_q;

endmodule

// File: hdl/stbs_checker.sv
// ----------------------------------------------------------------------------
// stbs_checker
// port-level checks of the sorted table binary search core
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_core_macros.svh"

module stbs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_action_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_found_i
);

  // a result waiting for the sink stays up with the same value
  `STBS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_found_i))

  // an accepted query keeps the block busy in the next cycle
  `STBS_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, in_valid_i && in_ready_i && (in_action_i == stbs_pkg::ACT_QUERY), !in_ready_i)

  // a load never causes a result
  `STBS_ASSERT_NEXT(a_load_silent, clk_i, rst_ni, in_valid_i && in_ready_i && (in_action_i == stbs_pkg::ACT_LOAD) && !out_valid_i, !out_valid_i)

  // a new result only ends a search that held the input off
  `STBS_ASSERT_NOW(a_result_after_busy, clk_i, rst_ni, $rose(out_valid_i), $past(!in_ready_i))

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .in_action_i (in_if.action),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_found_i (out_if.found)
);
